// File: hdl/robi_pkg.sv
// Shared constants and types for the yawed-box ray intersection pipeline.
// Used by robi_div and ray_oriented_box_intersect; depends on nothing.
package robi_pkg;

   // default coordinate width (bits taken from each coordinate port)
   localparam int COORD_WIDTH_DEF = 32;

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_X      = 3'd0,
      REG_CENTER_Y      = 3'd1,
      REG_CENTER_Z      = 3'd2,
      REG_HALF_EXTENT_X = 3'd3,
      REG_HALF_EXTENT_Y = 3'd4,
      REG_HALF_EXTENT_Z = 3'd5,
      REG_YAW_COS_SIN   = 3'd6,
      REG_BOX_ENABLED   = 3'd7
   } csr_index_type;

   // slab divider: signed numerator (bound - o) * 2^16, signed divisor
   localparam int NUM_W    = 53;
   localparam int DEN_W    = 35;
   // quotient magnitude bits kept; larger quotients saturate
   localparam int QUO_BITS = 31;
   // saturated quotient width, signed
   localparam int T_W      = QUO_BITS + 2;
   // divider pipeline registers: prepare, one stage per quotient bit, output
   localparam int DIV_LAT  = QUO_BITS + 2;

endpackage

// File: hdl/robi_div.sv
// Pipelined restoring divider for the slab parameters, one quotient bit per stage.
// Quotient truncates toward zero and is clamped to [-1, 2^QUO_BITS].
// Depends on robi_pkg.
module robi_div #(
   parameter int NUM_W    = robi_pkg::NUM_W,
   parameter int DEN_W    = robi_pkg::DEN_W,
   parameter int QUO_BITS = robi_pkg::QUO_BITS
) (
   input  logic                       clock,
   input  logic signed [NUM_W-1:0]    num,
   input  logic signed [DEN_W-1:0]    den,
   output logic signed [QUO_BITS+1:0] quo
);

   localparam int CMP_W = NUM_W + QUO_BITS;

   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic [NUM_W-1:0]    rem;
      logic [DEN_W-1:0]    dv;
      logic [QUO_BITS-1:0] q;
   } step_type;

   step_type step_ff [QUO_BITS+1];
   step_type step_in [QUO_BITS+1];
   logic signed [QUO_BITS+1:0] quo_ff, quo_in;

   // take magnitudes, note the sign and flag quotients beyond range
   always_comb begin : prep
      logic [NUM_W-1:0] n_mag;
      logic [DEN_W-1:0] d_mag;
      n_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      d_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      step_in[0].neg = num[NUM_W-1] ^ den[DEN_W-1];
      step_in[0].ovf = CMP_W'(n_mag) >= (CMP_W'(d_mag) << QUO_BITS);
      step_in[0].rem = n_mag;
      step_in[0].dv  = d_mag;
      step_in[0].q   = '0;
   end

   // one trial subtraction per stage, most significant bit first
   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
      localparam int K = QUO_BITS - j;
      always_comb begin
         logic [CMP_W-1:0] sub;
         step_in[j] = step_ff[j-1];
         sub = CMP_W'(step_ff[j-1].dv) << K;
         if (!step_ff[j-1].ovf && CMP_W'(step_ff[j-1].rem) >= sub) begin
            step_in[j].rem  = NUM_W'(CMP_W'(step_ff[j-1].rem) - sub);
            step_in[j].q[K] = 1'b1;
         end
      end
   end

   // apply the sign and clamp
   always_comb begin
      if (step_ff[QUO_BITS].neg) begin
         quo_in = (step_ff[QUO_BITS].ovf || step_ff[QUO_BITS].q != '0) ? '1 : '0;
      end else if (step_ff[QUO_BITS].ovf) begin
         quo_in = {2'b01, {QUO_BITS{1'b0}}};
      end else begin
         quo_in = {2'b00, step_ff[QUO_BITS].q};
      end
   end

   // advance every stage each cycle
   always_ff @(posedge clock) begin
      for (int j = 0; j <= QUO_BITS; j++) begin
         step_ff[j] <= step_in[j];
      end
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// File: hdl/ray_oriented_box_intersect.sv
// Ray versus yawed box slab test, fully pipelined, one ray per cycle.
// Depends on robi_pkg and robi_div.
//
//   channel   ports                         transfer
//   request   start, busy, req_*            start high and busy low at a clock edge
//   response  rsp_strobe, rsp_*             rsp_strobe high for one cycle
//   config    csr_we, csr_index, csr_wdata  csr_we high at a clock edge
//
// A ray can be taken every cycle; busy is always low. Each ray gives one
// response, computed through the six bit-per-stage slab dividers running
// in parallel after the origin, rotation, sum and numerator stages.
// Synchronous reset clears the valid bits and loads the register defaults.
// Responses cannot be held off, so the pipeline never stalls.
module ray_oriented_box_intersect #(
   parameter int COORD_WIDTH = robi_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [31:0]                  req_origin_x,
   input  logic signed [31:0]                  req_origin_y,
   input  logic signed [31:0]                  req_origin_z,
   input  logic signed [31:0]                  req_dir_x,
   input  logic signed [31:0]                  req_dir_y,
   input  logic signed [31:0]                  req_dir_z,
   input  logic        [30:0]                  req_max_dist,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic        [30:0]                  rsp_hit_distance,
   output logic signed [31:0]                  rsp_normal_x,
   output logic signed [31:0]                  rsp_normal_y,
   output logic signed [31:0]                  rsp_normal_z,
   input  logic                                csr_we,
   input  logic        [robi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [robi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW_EFF  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int T_W     = robi_pkg::T_W;
   localparam int DIV_LAT = robi_pkg::DIV_LAT;
   localparam logic signed [33:0] SAT_MAX = 34'((64'sd1 <<< (CW_EFF - 1)) - 64'sd1);
   localparam logic signed [33:0] SAT_MIN = -SAT_MAX - 34'sd1;
   localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef struct packed {
      logic signed [32:0] px, py, pz;
      logic signed [31:0] dx, dy, dz;
      logic [30:0]        tmax;
   } s1_type;

   typedef struct packed {
      logic signed [64:0] m_pxc, m_pzs, m_pxs, m_pzc;
      logic signed [63:0] m_dxc, m_dzs, m_dxs, m_dzc;
      logic signed [32:0] py;
      logic signed [31:0] dx, dy, dz;
      logic [30:0]        tmax;
   } s2_type;

   typedef struct packed {
      logic signed [35:0] lo0, lo1, lo2;
      logic signed [34:0] ld0, ld1, ld2;
      logic signed [31:0] dx, dy, dz;
      logic [30:0]        tmax;
   } s3_type;

   typedef struct packed {
      logic signed [31:0] dx, dy, dz;
      logic [30:0]        tmax;
      logic [2:0]         dzero;
      logic [2:0]         outside;
   } side_type;

   typedef struct packed {
      logic [2:0][T_W-1:0] tn, tf;
      logic [2:0]          spos;
      logic [2:0]          dzero;
      logic [2:0]          outside;
      logic signed [T_W-1:0] tmin, tmax;
      axis_type            axis;
      logic                ssel;
      logic signed [31:0]  dx, dy, dz;
   } work_type;

   // configuration registers
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        half_x_ff, half_y_ff, half_z_ff;
   logic [63:0]        yaw_ff;
   logic               enabled_ff;
   logic signed [31:0] cs, sn;

   // pipeline
   logic        req_go;
   logic        v1_ff, v2_ff, v3_ff, v4_ff, vsw_ff;
   logic [2:0]  vch_ff;
   logic [DIV_LAT-1:0] vdiv_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   side_type    s4_ff, s4_in;
   logic signed [robi_pkg::NUM_W-1:0] num_lo_ff [3];
   logic signed [robi_pkg::NUM_W-1:0] num_hi_ff [3];
   logic signed [robi_pkg::NUM_W-1:0] num_lo_in [3];
   logic signed [robi_pkg::NUM_W-1:0] num_hi_in [3];
   logic signed [robi_pkg::DEN_W-1:0] den_ff [3];
   logic signed [robi_pkg::DEN_W-1:0] den_in [3];
   logic signed [T_W-1:0] t_lo [3];
   logic signed [T_W-1:0] t_hi [3];
   side_type    side_ff [DIV_LAT];
   work_type    sw_ff, sw_in;
   work_type    ch_ff [3];
   work_type    ch_in [3];

   // response registers
   logic               out_strobe_ff, out_hit_ff, out_hit_in;
   logic [30:0]        out_dist_ff, out_dist_in;
   logic signed [31:0] out_nx_ff, out_ny_ff, out_nz_ff;
   logic signed [31:0] out_nx_in, out_ny_in, out_nz_in;

   function automatic logic signed [32:0] sext33(input logic [31:0] v);
      return {{(33 - CW_EFF){v[CW_EFF-1]}}, v[CW_EFF-1:0]};
   endfunction

   function automatic logic signed [31:0] sat_coord(input logic signed [33:0] v);
      logic signed [33:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

   assign busy   = 1'b0;
   assign req_go = start && !busy;
   assign cs     = signed'(yaw_ff[31:0]);
   assign sn     = signed'(yaw_ff[63:32]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         half_x_ff   <= '0;
         half_y_ff   <= '0;
         half_z_ff   <= '0;
         yaw_ff      <= 64'd1073741824;
         enabled_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (robi_pkg::csr_index_type'(csr_index))
            robi_pkg::REG_CENTER_X:      center_x_ff <= signed'(csr_wdata[31:0]);
            robi_pkg::REG_CENTER_Y:      center_y_ff <= signed'(csr_wdata[31:0]);
            robi_pkg::REG_CENTER_Z:      center_z_ff <= signed'(csr_wdata[31:0]);
            robi_pkg::REG_HALF_EXTENT_X: half_x_ff   <= csr_wdata[30:0];
            robi_pkg::REG_HALF_EXTENT_Y: half_y_ff   <= csr_wdata[30:0];
            robi_pkg::REG_HALF_EXTENT_Z: half_z_ff   <= csr_wdata[30:0];
            robi_pkg::REG_YAW_COS_SIN:   yaw_ff      <= csr_wdata;
            robi_pkg::REG_BOX_ENABLED:   enabled_ff  <= csr_wdata[0];
         endcase
      end
   end

   // stage 1: origin relative to centre
   always_comb begin
      logic signed [32:0] dxe, dye, dze;
      dxe = sext33(req_dir_x);
      dye = sext33(req_dir_y);
      dze = sext33(req_dir_z);
      s1_in.px   = 33'(sext33(req_origin_x) - sext33(center_x_ff));
      s1_in.py   = 33'(sext33(req_origin_y) - sext33(center_y_ff));
      s1_in.pz   = 33'(sext33(req_origin_z) - sext33(center_z_ff));
      s1_in.dx   = dxe[31:0];
      s1_in.dy   = dye[31:0];
      s1_in.dz   = dze[31:0];
      s1_in.tmax = req_max_dist;
   end

   // stage 2: rotation products
   always_comb begin
      logic signed [64:0] cs65, sn65;
      logic signed [63:0] cs64, sn64;
      cs65 = 65'(cs);
      sn65 = 65'(sn);
      cs64 = 64'(cs);
      sn64 = 64'(sn);
      s2_in.m_pxc = 65'(s1_ff.px) * cs65;
      s2_in.m_pzs = 65'(s1_ff.pz) * sn65;
      s2_in.m_pxs = 65'(s1_ff.px) * sn65;
      s2_in.m_pzc = 65'(s1_ff.pz) * cs65;
      s2_in.m_dxc = 64'(s1_ff.dx) * cs64;
      s2_in.m_dzs = 64'(s1_ff.dz) * sn64;
      s2_in.m_dxs = 64'(s1_ff.dx) * sn64;
      s2_in.m_dzc = 64'(s1_ff.dz) * cs64;
      s2_in.py    = s1_ff.py;
      s2_in.dx    = s1_ff.dx;
      s2_in.dy    = s1_ff.dy;
      s2_in.dz    = s1_ff.dz;
      s2_in.tmax  = s1_ff.tmax;
   end

   // stage 3: sum products and floor by 2^30
   always_comb begin
      logic signed [65:0] a0, a2;
      logic signed [64:0] b0, b2;
      a0 = 66'(s2_ff.m_pxc) - 66'(s2_ff.m_pzs);
      a2 = 66'(s2_ff.m_pxs) + 66'(s2_ff.m_pzc);
      b0 = 65'(s2_ff.m_dxc) - 65'(s2_ff.m_dzs);
      b2 = 65'(s2_ff.m_dxs) + 65'(s2_ff.m_dzc);
      s3_in.lo0  = a0[65:30];
      s3_in.lo1  = 36'(s2_ff.py);
      s3_in.lo2  = a2[65:30];
      s3_in.ld0  = b0[64:30];
      s3_in.ld1  = 35'(s2_ff.dy);
      s3_in.ld2  = b2[64:30];
      s3_in.dx   = s2_ff.dx;
      s3_in.dy   = s2_ff.dy;
      s3_in.dz   = s2_ff.dz;
      s3_in.tmax = s2_ff.tmax;
   end

   // stage 4: slab numerators, zero-direction slab checks
   always_comb begin : numer
      logic signed [35:0] o [3];
      logic signed [34:0] d [3];
      logic [30:0]        h [3];
      logic signed [36:0] hs, oe, lo_b, hi_b;
      o[0] = s3_ff.lo0;
      o[1] = s3_ff.lo1;
      o[2] = s3_ff.lo2;
      d[0] = s3_ff.ld0;
      d[1] = s3_ff.ld1;
      d[2] = s3_ff.ld2;
      h[0] = half_x_ff;
      h[1] = half_y_ff;
      h[2] = half_z_ff;
      s4_in.dx   = s3_ff.dx;
      s4_in.dy   = s3_ff.dy;
      s4_in.dz   = s3_ff.dz;
      s4_in.tmax = s3_ff.tmax;
      for (int i = 0; i < 3; i++) begin
         hs   = signed'({6'b0, h[i]});
         oe   = 37'(o[i]);
         lo_b = -hs - oe;
         hi_b = hs - oe;
         num_lo_in[i] = {lo_b, 16'b0};
         num_hi_in[i] = {hi_b, 16'b0};
         den_in[i]    = d[i];
         s4_in.dzero[i]   = (d[i] == '0);
         s4_in.outside[i] = (oe < -hs) || (oe > hs);
      end
   end

   // six slab dividers
   for (genvar i = 0; i < 3; i++) begin : g_axis
      robi_div #(
         .NUM_W   (robi_pkg::NUM_W),
         .DEN_W   (robi_pkg::DEN_W),
         .QUO_BITS(robi_pkg::QUO_BITS)
      ) u_div_lo (
         .clock(clock),
         .num  (num_lo_ff[i]),
         .den  (den_ff[i]),
         .quo  (t_lo[i])
      );
      robi_div #(
         .NUM_W   (robi_pkg::NUM_W),
         .DEN_W   (robi_pkg::DEN_W),
         .QUO_BITS(robi_pkg::QUO_BITS)
      ) u_div_hi (
         .clock(clock),
         .num  (num_hi_ff[i]),
         .den  (den_ff[i]),
         .quo  (t_hi[i])
      );
   end

   // order the slab parameters per axis
   always_comb begin
      side_type sd;
      sd = side_ff[DIV_LAT-1];
      for (int i = 0; i < 3; i++) begin
         if (t_lo[i] > t_hi[i]) begin
            sw_in.tn[i]   = t_hi[i];
            sw_in.tf[i]   = t_lo[i];
            sw_in.spos[i] = 1'b1;
         end else begin
            sw_in.tn[i]   = t_lo[i];
            sw_in.tf[i]   = t_hi[i];
            sw_in.spos[i] = 1'b0;
         end
      end
      sw_in.dzero   = sd.dzero;
      sw_in.outside = sd.outside;
      sw_in.tmin    = '0;
      sw_in.tmax    = signed'({2'b00, sd.tmax});
      sw_in.axis    = AXIS_NONE;
      sw_in.ssel    = 1'b0;
      sw_in.dx      = sd.dx;
      sw_in.dy      = sd.dy;
      sw_in.dz      = sd.dz;
   end

   // narrow the interval one axis per stage
   for (genvar j = 0; j < 3; j++) begin : g_chain
      always_comb begin
         work_type w;
         w = (j == 0) ? sw_ff : ch_ff[(j == 0) ? 0 : j - 1];
         ch_in[j] = w;
         if (!w.dzero[j]) begin
            if (signed'(w.tn[j]) > w.tmin) begin
               ch_in[j].tmin = signed'(w.tn[j]);
               ch_in[j].axis = axis_type'(2'(j));
               ch_in[j].ssel = w.spos[j];
            end
            if (signed'(w.tf[j]) < w.tmax) begin
               ch_in[j].tmax = signed'(w.tf[j]);
            end
         end
      end
   end

   // decide hit; entry face normal in world space, else the negated ray direction
   always_comb begin
      work_type w;
      logic signed [33:0] cv, sv, nx, ny, nz;
      logic               miss;
      w    = ch_ff[2];
      cv   = w.ssel ? 34'(cs) : -34'(cs);
      sv   = w.ssel ? 34'(sn) : -34'(sn);
      miss = !enabled_ff || ((w.dzero & w.outside) != 3'b000) || (w.tmin > w.tmax);
      unique case (w.axis)
         AXIS_X: begin
            nx = cv >>> 14;
            ny = '0;
            nz = (-sv) >>> 14;
         end
         AXIS_Y: begin
            nx = '0;
            ny = w.ssel ? ONE_Q16 : -ONE_Q16;
            nz = '0;
         end
         AXIS_Z: begin
            nx = sv >>> 14;
            ny = '0;
            nz = cv >>> 14;
         end
         AXIS_NONE: begin
            nx = -34'(w.dx);
            ny = -34'(w.dy);
            nz = -34'(w.dz);
         end
      endcase
      out_hit_in  = !miss;
      out_dist_in = miss ? '0 : w.tmin[30:0];
      out_nx_in   = miss ? '0 : sat_coord(nx);
      out_ny_in   = miss ? '0 : sat_coord(ny);
      out_nz_in   = miss ? '0 : sat_coord(nz);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         vdiv_ff       <= '0;
         vsw_ff        <= 1'b0;
         vch_ff        <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= req_go;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         vdiv_ff       <= {vdiv_ff[DIV_LAT-2:0], v4_ff};
         vsw_ff        <= vdiv_ff[DIV_LAT-1];
         vch_ff        <= {vch_ff[1:0], vsw_ff};
         out_strobe_ff <= vch_ff[2];
      end
   end

   // payload, advanced every cycle
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      for (int i = 0; i < 3; i++) begin
         num_lo_ff[i] <= num_lo_in[i];
         num_hi_ff[i] <= num_hi_in[i];
         den_ff[i]    <= den_in[i];
      end
      side_ff[0] <= s4_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      sw_ff <= sw_in;
      for (int j = 0; j < 3; j++) begin
         ch_ff[j] <= ch_in[j];
      end
      out_hit_ff  <= out_hit_in;
      out_dist_ff <= out_dist_in;
      out_nx_ff   <= out_nx_in;
      out_ny_ff   <= out_ny_in;
      out_nz_ff   <= out_nz_in;
   end

   assign rsp_strobe       = out_strobe_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_hit_distance = out_dist_ff;
   assign rsp_normal_x     = out_nx_ff;
   assign rsp_normal_y     = out_ny_ff;
   assign rsp_normal_z     = out_nz_ff;

endmodule
